// File: rtl/motor_setpoint_ramp_core_macros.svh
// Assertion macros for the motor setpoint ramp checker.
// Clocked on aclk; the reset-gated form uses the active-low aresetn.
`ifndef MOTOR_SETPOINT_RAMP_CORE_MACROS_SVH
`define MOTOR_SETPOINT_RAMP_CORE_MACROS_SVH

// Property checked only outside reset.
`define MSR_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("motor setpoint ramp check failed");

// Property checked on every edge, reset included.
`define MSR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("motor setpoint ramp reset check failed");

`endif

// File: rtl/msr_pkg.sv
// Shared types and constants of the motor setpoint ramp block.
// No dependencies.
package msr_pkg;

    // command codes carried in tuser
    localparam logic [1:0] ACT_TICK      = 2'd0;
    localparam logic [1:0] ACT_SET_ANGLE = 2'd1;
    localparam logic [1:0] ACT_SET_DRIVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR     = 2'd3;

    // drive direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    localparam logic [6:0] DRIVE_LIMIT = 7'd100;

    // configuration register map
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWEEP_ENABLE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVO_MAX_ANGLE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVO_MIN_ANGLE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_STEP      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVO_STEP      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWEEP_DRIVE_MAX = 3'd5;

    // register reset values
    localparam logic [6:0] RST_SERVO_MAX_ANGLE = 7'd90;
    localparam logic [7:0] RST_SERVO_MIN_ANGLE = 8'hA6;   // -90
    localparam logic [4:0] RST_DRIVE_STEP      = 5'd10;
    localparam logic [3:0] RST_SERVO_STEP      = 4'd10;
    localparam logic [6:0] RST_SWEEP_DRIVE_MAX = 7'd50;

    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic       sweep_enable;
        logic [6:0] servo_max_angle;
        logic [7:0] servo_min_angle;   // two's complement
        logic [4:0] drive_step;
        logic [3:0] servo_step;
        logic [6:0] sweep_drive_max;
    } msr_cfg_t;

    // one set of drive/servo values (actual or wanted)
    typedef struct packed {
        logic [6:0] drive;
        logic [1:0] direction;
        logic [7:0] angle;             // two's complement
    } msr_axes_t;

    typedef struct packed {
        logic angle_up;
        logic drive_up;
    } msr_sweep_t;

endpackage

// File: rtl/motor_setpoint_ramp_core.sv
// Motor setpoint ramp: command stream in, actual drive/servo word out.
// Depends on msr_pkg, msr_sweep and msr_ramp.
//
// Usage:
//   s_ channel carries one command word per beat. s_tuser[1:0] is the command
//   (tick, set angle, set drive, clear); s_tdata holds the angle and the
//   signed drive argument. Every command gives exactly one m_ word with the
//   actual drive percent, direction, servo angle and the two changed flags
//   (the flags are only ever set by a tick).
//   A command is captured in the input register, worked on from there and
//   shows on m_ from the output register. Throughput: one command per cycle
//   while m_tready does not hold the output. The whole update (optional
//   sweep of the targets, then one ramp step) is a single combinational pass
//   between the input and output registers, and the state registers update
//   in the same cycle, so the next command sees the result at once.
//   Stall: when m_tready is low the output word holds; one more command waits
//   in the input register, after which s_tready drops.
//   Reset (aresetn low, synchronous): both channels empty, state cleared,
//   config registers back to their defaults. The cfg_ port writes register
//   cfg_addr with cfg_wdata on any edge with cfg_we high; write only while
//   idle.
module motor_setpoint_ramp_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // command stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // target_angle, signed_drive
    input  logic [1:0]                          s_tuser,   // action
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // drive_percent, drive_direction, servo_angle, drive_changed, servo_changed
    output logic [msr_pkg::OUT_DATA_W-1:0]      m_tdata,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [msr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [msr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import msr_pkg::*;

    msr_cfg_t   cfg_reg;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_action_reg;
    logic [7:0] in_angle_reg;
    logic [7:0] in_drive_reg;

    // block state
    msr_axes_t  actual_reg, actual_next;
    msr_axes_t  wanted_reg, wanted_next;
    msr_sweep_t sweep_reg, sweep_next;

    // output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic       out_free;
    logic       advance;
    logic       is_tick;
    msr_axes_t  swept;
    msr_sweep_t sweep_swept;
    msr_axes_t  wanted_tick;
    msr_axes_t  ramped;
    logic [7:0] drive_mag;
    logic       drive_changed;
    logic       servo_changed;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign is_tick  = (in_action_reg == ACT_TICK);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sweep_enable    <= 1'b0;
            cfg_reg.servo_max_angle <= RST_SERVO_MAX_ANGLE;
            cfg_reg.servo_min_angle <= RST_SERVO_MIN_ANGLE;
            cfg_reg.drive_step      <= RST_DRIVE_STEP;
            cfg_reg.servo_step      <= RST_SERVO_STEP;
            cfg_reg.sweep_drive_max <= RST_SWEEP_DRIVE_MAX;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SWEEP_ENABLE:    cfg_reg.sweep_enable    <= cfg_wdata[0];
                CFG_SERVO_MAX_ANGLE: cfg_reg.servo_max_angle <= cfg_wdata[6:0];
                CFG_SERVO_MIN_ANGLE: cfg_reg.servo_min_angle <= cfg_wdata;
                CFG_DRIVE_STEP:      cfg_reg.drive_step      <= cfg_wdata[4:0];
                CFG_SERVO_STEP:      cfg_reg.servo_step      <= cfg_wdata[3:0];
                CFG_SWEEP_DRIVE_MAX: cfg_reg.sweep_drive_max <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // input register: loads whenever the slot is free or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_angle_reg  <= s_tdata[7:0];
            in_drive_reg  <= s_tdata[15:8];
        end
    end

    // tick datapath: sweep the targets when enabled, then one ramp step
    msr_sweep u_sweep (
        .cfg        (cfg_reg),
        .wanted_in  (wanted_reg),
        .sweep_in   (sweep_reg),
        .wanted_out (swept),
        .sweep_out  (sweep_swept)
    );

    assign wanted_tick = cfg_reg.sweep_enable ? swept : wanted_reg;

    msr_ramp u_ramp (
        .cfg        (cfg_reg),
        .actual_in  (actual_reg),
        .wanted_in  (wanted_tick),
        .actual_out (ramped)
    );

    // |signed_drive|, -128 gives 128 and saturates below
    assign drive_mag = in_drive_reg[7] ? (~in_drive_reg + 8'd1) : in_drive_reg;

    always_comb begin
        actual_next = actual_reg;
        wanted_next = wanted_reg;
        sweep_next  = sweep_reg;
        if (advance) begin
            case (in_action_reg)
                ACT_TICK: begin
                    actual_next = ramped;
                    wanted_next = wanted_tick;
                    if (cfg_reg.sweep_enable) begin
                        sweep_next = sweep_swept;
                    end
                end
                ACT_SET_ANGLE: begin
                    wanted_next.angle = in_angle_reg;
                end
                ACT_SET_DRIVE: begin
                    wanted_next.drive = (drive_mag > {1'b0, DRIVE_LIMIT})
                                      ? DRIVE_LIMIT : drive_mag[6:0];
                    if (in_drive_reg == 8'd0) begin
                        wanted_next.direction = DIR_STOP;
                    end else if (in_drive_reg[7]) begin
                        wanted_next.direction = DIR_BACK;
                    end else begin
                        wanted_next.direction = DIR_FWD;
                    end
                end
                ACT_CLEAR: begin
                    wanted_next.drive     = 7'd0;
                    wanted_next.direction = DIR_STOP;
                    wanted_next.angle     = 8'd0;
                end
                default: ;
            endcase
        end
    end

    assign drive_changed = is_tick && ((ramped.drive != actual_reg.drive)
                        || (ramped.direction != actual_reg.direction));
    assign servo_changed = is_tick && (ramped.angle != actual_reg.angle);

    // result word reports the state after this command
    assign m_data_next = {5'd0, servo_changed, drive_changed, actual_next.angle,
                          actual_next.direction, actual_next.drive};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            actual_reg  <= '0;
            wanted_reg  <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            actual_reg <= actual_next;
            wanted_reg <= wanted_next;
            sweep_reg  <= sweep_next;
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// File: rtl/msr_sweep.sv
// Test sweep of the wanted drive and angle, applied on a tick.
// Depends on msr_pkg.
module msr_sweep (
    input  msr_pkg::msr_cfg_t   cfg,
    input  msr_pkg::msr_axes_t  wanted_in,
    input  msr_pkg::msr_sweep_t sweep_in,
    output msr_pkg::msr_axes_t  wanted_out,
    output msr_pkg::msr_sweep_t sweep_out
);
    import msr_pkg::*;

    logic signed [9:0] ang_ext;
    logic signed [9:0] step_ext;
    logic signed [9:0] max_ext;
    logic signed [9:0] min_ext;
    logic signed [9:0] ang_sum;
    logic        [7:0] drv_ext;
    logic        [7:0] drv_sum;
    logic        [6:0] drv_new;

    assign ang_ext  = {{2{wanted_in.angle[7]}}, wanted_in.angle};
    assign step_ext = {6'd0, cfg.servo_step};
    assign max_ext  = {3'd0, cfg.servo_max_angle};
    assign min_ext  = {{2{cfg.servo_min_angle[7]}}, cfg.servo_min_angle};
    assign drv_ext  = {1'b0, wanted_in.drive};
    assign drv_sum  = drv_ext + {3'd0, cfg.drive_step};

    always_comb begin
        wanted_out = wanted_in;
        sweep_out  = sweep_in;
        ang_sum    = ang_ext;
        drv_new    = wanted_in.drive;

        // angle walks up past the maximum and down past the minimum angle, then turns
        if (sweep_in.angle_up) begin
            if (ang_ext <= max_ext) begin
                ang_sum = ang_ext + step_ext;
            end else begin
                sweep_out.angle_up = 1'b0;
            end
        end else begin
            if (ang_ext >= min_ext) begin
                ang_sum = ang_ext - step_ext;
            end else begin
                sweep_out.angle_up = 1'b1;
            end
        end

        if (ang_sum > 10'sd127) begin
            wanted_out.angle = 8'h7F;
        end else if (ang_sum < -10'sd128) begin
            wanted_out.angle = 8'h80;
        end else begin
            wanted_out.angle = ang_sum[7:0];
        end

        // drive ramps up past the sweep maximum, then back down to one step or less
        if (sweep_in.drive_up) begin
            if (drv_ext <= {1'b0, cfg.sweep_drive_max}) begin
                drv_new = (drv_sum > {1'b0, DRIVE_LIMIT}) ? DRIVE_LIMIT : drv_sum[6:0];
            end else begin
                sweep_out.drive_up = 1'b0;
            end
        end else begin
            if (drv_ext > {3'd0, cfg.drive_step}) begin
                drv_new = wanted_in.drive - {2'd0, cfg.drive_step};
            end else begin
                sweep_out.drive_up = 1'b1;
            end
        end

        wanted_out.drive     = drv_new;
        wanted_out.direction = (drv_new != 7'd0) ? DIR_FWD : DIR_STOP;
    end

endmodule

// File: rtl/msr_ramp.sv
// Slew-rate step of the actual drive and servo angle towards the wanted values.
// Depends on msr_pkg.
module msr_ramp (
    input  msr_pkg::msr_cfg_t  cfg,
    input  msr_pkg::msr_axes_t actual_in,
    input  msr_pkg::msr_axes_t wanted_in,
    output msr_pkg::msr_axes_t actual_out
);
    import msr_pkg::*;

    logic       [6:0] gap;
    logic       [6:0] move;
    logic             drv_below;
    logic             cross_zero;
    logic signed [9:0] a_ext;
    logic signed [9:0] w_ext;
    logic signed [9:0] s_ext;
    logic signed [9:0] a_up;
    logic signed [9:0] a_dn;

    assign drv_below = actual_in.drive < wanted_in.drive;
    assign gap  = drv_below ? (wanted_in.drive - actual_in.drive)
                            : (actual_in.drive - wanted_in.drive);
    // twice the step once the gap exceeds four steps
    assign move = ({1'b0, gap} > {1'b0, cfg.drive_step, 2'b00})
                ? {1'b0, cfg.drive_step, 1'b0} : {2'd0, cfg.drive_step};

    assign a_ext = {{2{actual_in.angle[7]}}, actual_in.angle};
    assign w_ext = {{2{wanted_in.angle[7]}}, wanted_in.angle};
    // double step when the move crosses zero
    assign cross_zero = (a_ext < 10'sd0 && w_ext > 10'sd0)
                     || (a_ext > 10'sd0 && w_ext < 10'sd0);
    assign s_ext = cross_zero ? {5'd0, cfg.servo_step, 1'b0} : {6'd0, cfg.servo_step};
    assign a_up  = a_ext + s_ext;
    assign a_dn  = a_ext - s_ext;

    always_comb begin
        actual_out = actual_in;

        // drive: a direction change stops the motor first
        if (actual_in.direction != wanted_in.direction) begin
            actual_out.direction = wanted_in.direction;
            actual_out.drive     = 7'd0;
        end else if (gap == 7'd0) begin
            actual_out.drive = actual_in.drive;
        end else if ({1'b0, gap} <= {3'd0, cfg.drive_step}) begin
            actual_out.drive = wanted_in.drive;
        end else if (drv_below) begin
            actual_out.drive = actual_in.drive + move;
        end else begin
            actual_out.drive = actual_in.drive - move;
        end

        // servo: never past the target
        if (a_ext < w_ext) begin
            actual_out.angle = (a_up > w_ext) ? wanted_in.angle : a_up[7:0];
        end else if (a_ext > w_ext) begin
            actual_out.angle = (a_dn < w_ext) ? wanted_in.angle : a_dn[7:0];
        end
    end

endmodule

// File: rtl/msr_checker.sv
// Port-level checks of the motor setpoint ramp core, bound to the top level.
// Depends on msr_pkg and motor_setpoint_ramp_core_macros.svh.
`include "motor_setpoint_ramp_core_macros.svh"

module msr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [msr_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import msr_pkg::*;

    // reset empties the result channel
    `MSR_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid)

    // drive percent never leaves its range
    `MSR_ASSERT(a_drive_range, m_tvalid |-> (m_tdata[6:0] <= DRIVE_LIMIT))

    // a stopped motor reports zero drive
    `MSR_ASSERT(a_stop_zero, (m_tvalid && (m_tdata[8:7] == DIR_STOP)) |-> (m_tdata[6:0] == 7'd0))

    // a stalled result stays offered
    `MSR_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> m_tvalid)

    // with the result side empty an offered command is always taken
    `MSR_ASSERT(a_ready_when_empty, (s_tvalid && !m_tvalid) |-> s_tready)

endmodule

bind motor_setpoint_ramp_core msr_checker u_msr_checker (.*);
